// ===== design/csem_pkg.sv =====
// shared types and constants for the counting semaphore table
package csem_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = 16;

	localparam logic signed [CNT_W-1:0] COUNT_MAX   = 16'sh7fff;
	localparam logic signed [CNT_W-1:0] COUNT_MIN   = 16'sh8000;
	localparam logic        [CNT_W-1:0] WAITERS_MAX = 16'hffff;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_P      = 2'd1,
		KIND_V      = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== design/csem_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module csem_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/csem_ctrl.sv =====
// controller state machine sequencing capture and execution of one request
module csem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  csem_pkg::sts_t    sts,
	output csem_pkg::cmd_t    cmd
);

	csem_pkg::state_t state_q;
	csem_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csem_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			csem_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = csem_pkg::ST_EXEC;
				end
			end
			csem_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					state_d = csem_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csem_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			csem_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			csem_pkg::ST_EXEC: begin
				cmd.execute = sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== design/csem_dp.sv =====
// datapath: request registers, fill counter, entry update and result register
module csem_dp #(
	parameter int NUM_SEMS = 32,
	parameter int IDX_W = 5,
	parameter int FILL_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csem_pkg::cmd_t      cmd,
	output csem_pkg::sts_t      sts,
	input  logic [1:0]          kind,
	input  logic signed [7:0]   sem_index,
	input  logic signed [15:0]  start_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [4:0]          new_index,
	output logic                must_block,
	output logic                wake_one
);

	logic [1:0]                          kind_q;
	logic [7:0]                          idx_q;
	logic signed [csem_pkg::CNT_W-1:0]   init_q;
	logic [FILL_W-1:0]                   fill_q;
	logic                                out_valid_q;
	logic                                status_q;
	logic [4:0]                          new_index_q;
	logic                                block_q;
	logic                                wake_q;

	logic [csem_pkg::WORD_W-1:0]         rd_word;
	logic [csem_pkg::WORD_W-1:0]         wr_word;
	logic [IDX_W-1:0]                    wr_addr;
	logic                                wr_en;
	logic signed [csem_pkg::CNT_W-1:0]   cnt;
	logic signed [csem_pkg::CNT_W-1:0]   cnt_n;
	logic [csem_pkg::CNT_W-1:0]          wt;
	logic [csem_pkg::CNT_W-1:0]          wt_n;
	logic                                idx_ok;
	logic                                full;
	logic                                ok;
	logic                                blk;
	logic                                wak;
	logic                                is_create;

	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			idx_q  <= sem_index;
			init_q <= start_count;
		end
	end

	csem_ram #(
		.WIDTH (csem_pkg::WORD_W),
		.DEPTH (NUM_SEMS),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_word),
		.rd_en  (cmd.capture),
		.rd_addr(sem_index[IDX_W-1:0]),
		.rd_data(rd_word)
	);

	assign cnt = rd_word[csem_pkg::WORD_W-1:csem_pkg::CNT_W];
	assign wt  = rd_word[csem_pkg::CNT_W-1:0];

	// entries are claimed in order and never released, so used means below the fill count
	assign idx_ok = !idx_q[7] && ({1'b0, idx_q[6:0]} < 8'(fill_q));
	assign full   = fill_q == FILL_W'(NUM_SEMS);

	always_comb begin
		ok        = 1'b0;
		blk       = 1'b0;
		wak       = 1'b0;
		is_create = 1'b0;
		cnt_n     = cnt;
		wt_n      = wt;
		case (kind_q)
			csem_pkg::KIND_CREATE: begin
				is_create = 1'b1;
				ok        = !init_q[csem_pkg::CNT_W-1] && !full;
				cnt_n     = init_q;
				wt_n      = '0;
			end
			csem_pkg::KIND_P: begin
				ok = idx_ok;
				if (cnt != csem_pkg::COUNT_MIN) begin
					cnt_n = cnt - 16'sd1;
				end
				if (cnt_n[csem_pkg::CNT_W-1]) begin
					blk = 1'b1;
					if (wt != csem_pkg::WAITERS_MAX) begin
						wt_n = wt + 16'd1;
					end
				end
			end
			csem_pkg::KIND_V: begin
				ok = idx_ok;
				if (cnt != csem_pkg::COUNT_MAX) begin
					cnt_n = cnt + 16'sd1;
				end
				if ((cnt_n[csem_pkg::CNT_W-1] || cnt_n == '0) && wt != '0) begin
					wak  = 1'b1;
					wt_n = wt - 16'd1;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign wr_en   = cmd.execute && ok;
	assign wr_addr = is_create ? fill_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign wr_word = {cnt_n, wt_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.execute && ok && is_create) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q    <= !ok;
			new_index_q <= (ok && is_create) ? 5'(fill_q) : 5'd0;
			block_q     <= ok && blk;
			wake_q      <= ok && wak;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign new_index  = new_index_q;
	assign must_block = block_q;
	assign wake_one   = wake_q;

endmodule

// ===== design/counting_semaphore_table_core.sv =====
// top level of the counting semaphore table
//
// request channel: in_valid/in_stall with kind, sem_index and start_count.
// create claims the lowest free entry and returns its index in new_index;
// p decrements a count and flags must_block when it goes negative; v
// increments it and flags wake_one when a waiter is released.
// result channel: out_valid/out_stall with status, new_index, must_block and
// wake_one; exactly one result word per request word.
// each request has a read step that reads the entry from the table ram
// (registered read) and an update step that writes it and loads the result
// register; a new request word is taken only after the previous one is updated.
// the result register sits between the two sides: a request is taken while
// the previous result still waits; if the receiver stalls, the next request
// holds in its update cycle until the result register frees.
// entries are claimed in index order and never freed, so a fill counter
// marks the used ones; reset clears it and the handshake state at once, with
// no clearing pass over the table.
module counting_semaphore_table_core #(
	parameter int NUM_SEMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [7:0]  sem_index,
	input  logic signed [15:0] start_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [4:0]         new_index,
	output logic               must_block,
	output logic               wake_one
);

	localparam int IDX_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int FILL_W = $clog2(NUM_SEMS + 1);

	csem_pkg::cmd_t cmd;
	csem_pkg::sts_t sts;

	csem_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	csem_dp #(
		.NUM_SEMS(NUM_SEMS),
		.IDX_W   (IDX_W),
		.FILL_W  (FILL_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.sem_index    (sem_index),
		.start_count  (start_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.new_index    (new_index),
		.must_block   (must_block),
		.wake_one     (wake_one)
	);

endmodule

// ===== bench/testbench.sv =====
// testbench for the counting semaphore table: directed rows, a deep wait run, random traffic
module testbench;

	localparam int SEM_SLOTS = 32;
	localparam logic [1:0] KIND_BAD = 2'd3;
	localparam int DEEP_WAITS = 40;

	typedef struct packed {
		logic       status;
		logic [4:0] new_index;
		logic       must_block;
		logic       wake_one;
	} result_t;

	typedef struct packed {
		logic [1:0]         k;
		logic signed [7:0]  idx;
		logic signed [15:0] init;
		logic               pin;
		result_t            want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         kind = csem_pkg::KIND_CREATE;
	logic signed [7:0]  sem_index = '0;
	logic signed [15:0] start_count = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               status;
	logic [4:0]         new_index;
	logic               must_block;
	logic               wake_one;

	logic               sem_used [SEM_SLOTS];
	logic signed [15:0] sem_count [SEM_SLOTS];
	logic [15:0]        sem_waiters [SEM_SLOTS];
	int                 sems_claimed = 0;

	result_t pending_results [$];
	row_t    plan [$];
	int      failures = 0;
	int      words_sent = 0;
	int      refused = 0;
	int      blocks_seen = 0;
	int      wakes_seen = 0;
	int      burst_left = 0;
	int      stall_left = 0;
	int      stall_mode = 0;

	counting_semaphore_table_core #(
		.NUM_SEMS(SEM_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.sem_index(sem_index),
		.start_count(start_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.new_index(new_index),
		.must_block(must_block),
		.wake_one(wake_one)
	);

	always #5 clk = ~clk;

	function automatic result_t serve_request(logic [1:0] k, logic signed [7:0] idx,
			logic signed [15:0] init);
		result_t r;
		int      slot;
		int      i;
		r = '0;
		r.status = 1'b1;
		slot = -1;
		if (k == csem_pkg::KIND_CREATE) begin
			if (init >= 0) begin
				for (i = SEM_SLOTS - 1; i >= 0; i--)
					if (!sem_used[i])
						slot = i;
				if (slot >= 0) begin
					sem_used[slot] = 1'b1;
					sem_count[slot] = init;
					sem_waiters[slot] = '0;
					r.new_index = slot[4:0];
					r.status = 1'b0;
					sems_claimed++;
				end
			end
		end else if (k == csem_pkg::KIND_P || k == csem_pkg::KIND_V) begin
			if (idx >= 0 && idx < SEM_SLOTS && sem_used[int'(idx)])
				slot = int'(idx);
			if (slot >= 0 && k == csem_pkg::KIND_P) begin
				if (sem_count[slot] != csem_pkg::COUNT_MIN)
					sem_count[slot] = sem_count[slot] - 16'sd1;
				if (sem_count[slot] < 0) begin
					if (sem_waiters[slot] != csem_pkg::WAITERS_MAX)
						sem_waiters[slot] = sem_waiters[slot] + 16'd1;
					r.must_block = 1'b1;
				end
				r.status = 1'b0;
			end else if (slot >= 0) begin
				if (sem_count[slot] != csem_pkg::COUNT_MAX)
					sem_count[slot] = sem_count[slot] + 16'sd1;
				if (sem_count[slot] <= 0 && sem_waiters[slot] != 0) begin
					sem_waiters[slot] = sem_waiters[slot] - 16'd1;
					r.wake_one = 1'b1;
				end
				r.status = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic row_t row(logic [1:0] k, int idx, int init, bit pin = 1'b0,
			int st = 0, int ni = 0, int mb = 0, int wk = 0);
		row_t w;
		w.k = k;
		w.idx = 8'(idx);
		w.init = 16'(init);
		w.pin = pin;
		w.want.status = 1'(st);
		w.want.new_index = 5'(ni);
		w.want.must_block = 1'(mb);
		w.want.wake_one = 1'(wk);
		return w;
	endfunction

	task automatic issue(input row_t w);
		result_t predicted;
		int      gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		kind <= w.k;
		sem_index <= w.idx;
		start_count <= w.init;
		do @(posedge clk); while (in_stall);
		burst_left--;
		predicted = serve_request(w.k, w.idx, w.init);
		if (w.pin)
			predicted = w.want;
		pending_results.push_back(predicted);
		words_sent++;
		refused += predicted.status;
		blocks_seen += predicted.must_block;
		wakes_seen += predicted.wake_one;
	endtask

	task automatic flag_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(4, 40);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= (stall_left % 4 != 0);
		endcase
	end

	always @(posedge clk) begin : watch_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected: status %0b index %0d",
					$time, status, new_index);
				failures++;
			end else begin
				want = pending_results.pop_front();
				flag_field("status", int'(want.status), int'(status));
				flag_field("new_index", int'(want.new_index), int'(new_index));
				flag_field("must_block", int'(want.must_block), int'(must_block));
				flag_field("wake_one", int'(want.wake_one), int'(wake_one));
			end
		end
	end

	initial begin
		#40_000_000;
		$display("counting_semaphore_table_core: mismatch");
		$finish;
	end

	initial begin : stimulus
		row_t w;
		int   deep_slot;
		int   n;
		int   sel;
		for (n = 0; n < SEM_SLOTS; n++) begin
			sem_used[n] = 1'b0;
			sem_count[n] = -16'sd1;
			sem_waiters[n] = '0;
		end

		// errors on an empty table, creates, saturation at the top, bad indexes
		plan.push_back(row(csem_pkg::KIND_P, 0, 0, 1, 1));
		plan.push_back(row(csem_pkg::KIND_V, 5, 0, 1, 1));
		plan.push_back(row(KIND_BAD, 0, 0, 1, 1));
		plan.push_back(row(csem_pkg::KIND_CREATE, 0, -32768, 1, 1));
		plan.push_back(row(csem_pkg::KIND_CREATE, 0, -1, 1, 1));
		plan.push_back(row(csem_pkg::KIND_CREATE, -128, 0, 1, 0, 0));
		plan.push_back(row(csem_pkg::KIND_CREATE, 127, 32767, 1, 0, 1));
		plan.push_back(row(csem_pkg::KIND_V, 1, -32768, 1, 0));
		plan.push_back(row(csem_pkg::KIND_P, 0, 0));
		plan.push_back(row(csem_pkg::KIND_P, 0, -32768));
		plan.push_back(row(csem_pkg::KIND_V, 0, 32767));
		plan.push_back(row(csem_pkg::KIND_V, 0, 0));
		plan.push_back(row(csem_pkg::KIND_V, 0, 0));
		plan.push_back(row(csem_pkg::KIND_P, -128, 0, 1, 1));
		plan.push_back(row(csem_pkg::KIND_P, -1, 0, 1, 1));
		plan.push_back(row(csem_pkg::KIND_V, SEM_SLOTS, 0, 1, 1));
		plan.push_back(row(csem_pkg::KIND_P, 127, 0, 1, 1));
		plan.push_back(row(csem_pkg::KIND_V, 31, 0, 1, 1));
		plan.push_back(row(csem_pkg::KIND_CREATE, 5, 1, 1, 0, 2));
		plan.push_back(row(csem_pkg::KIND_CREATE, 0, 32766, 1, 0, 3));
		plan.push_back(row(csem_pkg::KIND_V, 3, 0));
		plan.push_back(row(csem_pkg::KIND_V, 3, 0));
		plan.push_back(row(csem_pkg::KIND_P, 2, 0));
		plan.push_back(row(csem_pkg::KIND_P, 2, 0));
		plan.push_back(row(KIND_BAD, -1, -1, 1, 1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue(plan[i]);

		// pile waiters onto one entry, then release them again
		deep_slot = sems_claimed;
		issue(row(csem_pkg::KIND_CREATE, $urandom_range(0, 255), 0));
		for (n = 0; n < DEEP_WAITS; n++)
			issue(row(csem_pkg::KIND_P, deep_slot, $urandom()));
		for (n = 0; n < 40; n++)
			issue(row(csem_pkg::KIND_V, deep_slot, $urandom()));

		for (n = 0; n < 400; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 14 || (sel >= 28 && sems_claimed == 0)) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: w = row(csem_pkg::KIND_CREATE, $urandom(),
						$urandom_range(0, 4));
					6: w = row(csem_pkg::KIND_CREATE, $urandom(), $urandom_range(0, 32767));
					7: w = row(csem_pkg::KIND_CREATE, $urandom(), 32767);
					8: w = row(csem_pkg::KIND_CREATE, $urandom(),
						-int'($urandom_range(1, 32768)));
					default: w = row(csem_pkg::KIND_CREATE, $urandom(), $urandom());
				endcase
			end else if (sel < 18) begin
				w = row(KIND_BAD, $urandom(), $urandom());
			end else if (sel < 28) begin
				w = row($urandom_range(0, 1) ? csem_pkg::KIND_P : csem_pkg::KIND_V,
					$urandom(), $urandom());
			end else begin
				w = row($urandom_range(0, 1) ? csem_pkg::KIND_P : csem_pkg::KIND_V,
					$urandom_range(0, sems_claimed - 1), $urandom());
			end
			issue(w);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("request words: %0d, refused %0d, blocking waits %0d, wake-ups %0d",
			words_sent, refused, blocks_seen, wakes_seen);
		$display("entries claimed %0d of %0d; entry %0d took a deep queue of waiters",
			sems_claimed, SEM_SLOTS, deep_slot);
		if (failures == 0)
			$display("counting_semaphore_table_core: match");
		else
			$display("counting_semaphore_table_core: mismatch");
		$finish;
	end

endmodule
